// ===== sv/cht_pkg.sv =====
// package for the chained hash table: sizes, opcodes, status codes, fsm states
// no dependencies
package cht_pkg;
  localparam int BucketsDef = 256;
  localparam int NodesDef   = 1024;
  localparam int KeyW       = 31;
  localparam int ValW       = 64;
  localparam int CfgW       = 9;
  localparam int BucketOutW = 8;
  localparam logic [CfgW-1:0] TableSizeRst = 9'd179;

  localparam logic [1:0] FuncInsert = 2'd0;
  localparam logic [1:0] FuncSearch = 2'd1;
  localparam logic [1:0] FuncRemove = 2'd2;
  localparam logic [1:0] FuncUnused = 2'd3;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StMiss    = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_HEAD, S_FREE, S_WALK, S_NODE, S_FIX, S_OUT
  } state_t;
endpackage

// ===== sv/cht_ram.sv =====
// generic single port write, single port read ram with registered read
// no dependencies
module cht_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/cht_mod.sv =====
// iterative key modulo table size, one quotient bit per cycle
// depends on cht_pkg
module cht_mod
  import cht_pkg::*;
#(
  parameter int BW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [KeyW-1:0] key,
  input  logic [BW:0]     modulus,
  output logic            done,
  output logic [BW-1:0]   rem
);
  localparam int CW = $clog2(KeyW + 1);
  logic [KeyW-1:0] sh_r, sh_nxt;
  logic [BW:0]     rem_r, rem_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [BW+1:0]   trial;

  always_comb begin
    sh_nxt = sh_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = {rem_r, sh_r[KeyW-1]};
    if (start) begin
      sh_nxt = key; rem_nxt = '0; cnt_nxt = CW'(KeyW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below modulus so one compare and subtract per bit
      if (trial >= {1'b0, modulus}) rem_nxt = (BW+1)'(trial - {1'b0, modulus});
      else rem_nxt = trial[BW:0];
      sh_nxt = sh_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    sh_r <= sh_nxt; rem_r <= rem_nxt;
  end

  assign done = busy_r && cnt_r == CW'(1) && !start;
  assign rem  = rem_nxt[BW-1:0];
endmodule

// ===== sv/chained_hash_table.sv =====
// the serial key modulo comes first, then head read, free pool read on insert,
// node walk and write-back. one item at a time: the next beat is taken in the
// cycle after the result beat at the earliest.
// reset is synchronous: a clearing pass over max(BUCKETS, NODES) addresses
// empties the heads and fills the free pool; no beat is accepted during it.
module chained_hash_table
  import cht_pkg::*;
#(
  parameter int BUCKETS = BucketsDef,
  parameter int NODES   = NodesDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CfgW-1:0]       cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [KeyW-1:0]       in_key,
  input  logic [ValW-1:0]       in_record_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [ValW-1:0]       out_found_value,
  output logic [BucketOutW-1:0] out_bucket
);
  localparam int BW = $clog2(BUCKETS);
  localparam int NW = $clog2(NODES);
  localparam int PW = NW + 1;  // node pointer with nil
  localparam int CLW = (BW > NW) ? BW : NW;
  localparam logic [PW-1:0] Nil = PW'(NODES);
  localparam int NDW = KeyW + ValW + PW;

  state_t state_r, state_nxt;
  logic [CfgW-1:0] tsize_r;
  logic [1:0]      func_r, func_nxt;
  logic [KeyW-1:0] key_r, key_nxt;
  logic [ValW-1:0] val_r, val_nxt;
  logic [BW-1:0]   bkt_r, bkt_nxt;
  logic [PW-1:0]   cur_r, cur_nxt, prev_r, prev_nxt, newn_r, newn_nxt;
  logic [PW-1:0]   fcnt_r, fcnt_nxt;
  logic [CLW:0]    clr_r, clr_nxt;
  logic [PW-1:0]   link_r, link_nxt;
  logic [ValW-1:0] fval_r, fval_nxt;
  logic [1:0]      ost_r, ost_nxt;
  logic            ovalid_r, ovalid_nxt;

  // found flag, found node, and predecessor contents for the relink write
  logic            found_r, found_nxt;
  logic [PW-1:0]   fcur_r, fcur_nxt;
  logic [KeyW-1:0] pkey_r, pkey_nxt;
  logic [ValW-1:0] pval_r, pval_nxt;

  // memories
  logic           h_we;   logic [BW-1:0] h_wa, h_ra; logic [PW-1:0] h_wd, h_rd;
  logic           n_we;   logic [NW-1:0] n_wa, n_ra; logic [NDW-1:0] n_wd, n_rd;
  logic           f_we;   logic [NW-1:0] f_wa, f_ra; logic [NW-1:0] f_wd, f_rd;

  cht_ram #(.W(PW), .D(BUCKETS)) u_head (.clk, .we(h_we), .waddr(h_wa), .wdata(h_wd),
    .raddr(h_ra), .rdata(h_rd));
  cht_ram #(.W(NDW), .D(NODES)) u_node (.clk, .we(n_we), .waddr(n_wa), .wdata(n_wd),
    .raddr(n_ra), .rdata(n_rd));
  cht_ram #(.W(NW), .D(NODES)) u_free (.clk, .we(f_we), .waddr(f_wa), .wdata(f_wd),
    .raddr(f_ra), .rdata(f_rd));

  logic [KeyW-1:0] nd_key; logic [ValW-1:0] nd_val; logic [PW-1:0] nd_link;
  assign {nd_key, nd_val, nd_link} = n_rd;

  // modulus in use, clamped to 1..BUCKETS
  logic [BW:0] modulus;
  always_comb begin
    if (tsize_r == '0) modulus = (BW+1)'(1);
    else if (32'(tsize_r) > BUCKETS) modulus = (BW+1)'(BUCKETS);
    else modulus = (BW+1)'(tsize_r);
  end

  // modulo starts on the accepting edge, so it takes the key from the port
  logic mod_start, mod_done; logic [BW-1:0] mod_rem;
  cht_mod #(.BW(BW)) u_mod (.clk, .rst_n, .start(mod_start), .key(in_key),
    .modulus(modulus), .done(mod_done), .rem(mod_rem));

  logic in_acc, out_acc;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign in_ready = state_r == S_IDLE && !ovalid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == (CLW+1)'(((BUCKETS > NODES) ? BUCKETS : NODES) - 1))
                 state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = S_MOD;
      S_MOD:   if (mod_done) state_nxt = S_HEAD;
      S_HEAD:  state_nxt = (func_r == FuncInsert) ? S_FREE : S_WALK;
      S_FREE:  state_nxt = S_WALK;
      S_WALK:  state_nxt = (cur_r == Nil) ? S_FIX : S_NODE;
      S_NODE:  state_nxt = S_WALK;
      S_FIX:   state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic hit, ins, full;
  assign ins  = func_r == FuncInsert;
  assign full = fcnt_r == '0;
  assign hit  = !ins && nd_key == key_r;

  // datapath and ram control
  always_comb begin
    func_nxt = func_r; key_nxt = key_r; val_nxt = val_r; bkt_nxt = bkt_r;
    cur_nxt = cur_r; prev_nxt = prev_r; newn_nxt = newn_r; fcnt_nxt = fcnt_r;
    clr_nxt = clr_r; link_nxt = link_r; fval_nxt = fval_r; ost_nxt = ost_r;
    ovalid_nxt = ovalid_r;
    mod_start = 1'b0;
    h_we = 1'b0; h_wa = bkt_r; h_wd = Nil; h_ra = bkt_r;
    n_we = 1'b0; n_wa = cur_r[NW-1:0]; n_wd = '0; n_ra = cur_r[NW-1:0];
    f_we = 1'b0; f_wa = fcnt_r[NW-1:0]; f_wd = '0; f_ra = NW'(fcnt_r - 1'b1);
    if (out_acc) ovalid_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r < (CLW+1)'(BUCKETS)) begin
          h_we = 1'b1; h_wa = clr_r[BW-1:0]; h_wd = Nil;
        end
        if (clr_r < (CLW+1)'(NODES)) begin
          f_we = 1'b1; f_wa = clr_r[NW-1:0]; f_wd = clr_r[NW-1:0];
        end
      end
      S_IDLE: if (in_acc) begin
        func_nxt = in_func; key_nxt = in_key; val_nxt = in_record_value;
        mod_start = 1'b1;
      end
      S_MOD: if (mod_done) begin
        bkt_nxt = mod_rem; h_ra = mod_rem;
      end
      S_HEAD: begin
        cur_nxt = h_rd; prev_nxt = Nil; link_nxt = h_rd;
      end
      S_FREE: newn_nxt = {1'b0, f_rd};
      S_WALK: begin
        // issue node read; for insert stop at tail or on full pool
        if (ins && (full || cur_r == Nil)) cur_nxt = cur_r;
      end
      S_NODE: begin
        if (ins) begin
          if (nd_link == Nil) link_nxt = Nil;  // cur is the tail
          else begin prev_nxt = cur_r; cur_nxt = nd_link; end
          if (nd_link == Nil) begin
            prev_nxt = cur_r; cur_nxt = Nil;
          end
        end else if (hit) begin
          fval_nxt = nd_val; link_nxt = nd_link;
          // stop walking: found is flagged and cur forced to nil, so the walk ends at fix
        end else begin
          prev_nxt = cur_r; cur_nxt = nd_link;
        end
      end
      S_FIX: begin
        ovalid_nxt = 1'b1; ost_nxt = StMiss; fval_nxt = '0;
        if (ins) begin
          if (full || func_r != FuncInsert) ost_nxt = StFull;
          else begin
            ost_nxt = StDone; fcnt_nxt = fcnt_r - 1'b1;
            n_we = 1'b1; n_wa = newn_r[NW-1:0]; n_wd = {key_r, val_r, Nil};
            if (prev_r == Nil) begin h_we = 1'b1; h_wd = newn_r; end
          end
        end else if (found_r && func_r == FuncRemove) begin
          ost_nxt = StDone; fval_nxt = fval_r;
          if (prev_r == Nil) begin h_we = 1'b1; h_wd = link_r; end
          if (fcnt_r < PW'(NODES)) begin
            f_we = 1'b1; f_wa = fcnt_r[NW-1:0]; f_wd = fcur_r[NW-1:0];
            fcnt_nxt = fcnt_r + 1'b1;
          end
        end else if (found_r && func_r == FuncSearch) begin
          ost_nxt = StDone; fval_nxt = fval_r;
        end
      end
      S_OUT: begin
        // second write for predecessor link fix
        if (ins && !full && prev_r != Nil && ost_r == StDone) begin
          n_we = 1'b1; n_wa = prev_r[NW-1:0]; n_wd = {pkey_r, pval_r, newn_r};
        end
        if (func_r == FuncRemove && ost_r == StDone && prev_r != Nil) begin
          n_we = 1'b1; n_wa = prev_r[NW-1:0]; n_wd = {pkey_r, pval_r, link_r};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    found_nxt = found_r; fcur_nxt = fcur_r;
    pkey_nxt = pkey_r; pval_nxt = pval_r;
    if (state_r == S_HEAD) found_nxt = 1'b0;
    if (state_r == S_NODE) begin
      if (hit) begin found_nxt = 1'b1; fcur_nxt = cur_r; end
      else begin pkey_nxt = nd_key; pval_nxt = nd_val; end
    end
  end

  // walk exit: found, or insert with a full pool, forces cur to nil
  logic [PW-1:0] cur_fin;
  always_comb begin
    cur_fin = cur_nxt;
    if (state_r == S_NODE && hit) cur_fin = Nil;
    if (state_r == S_WALK && ins && full) cur_fin = Nil;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; fcnt_r <= PW'(NODES);
      tsize_r <= TableSizeRst; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; fcnt_r <= fcnt_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) tsize_r <= cfg_wdata;
    end
    func_r <= func_nxt; key_r <= key_nxt; val_r <= val_nxt; bkt_r <= bkt_nxt;
    cur_r <= cur_fin; prev_r <= prev_nxt; newn_r <= newn_nxt; link_r <= link_nxt;
    fval_r <= fval_nxt; ost_r <= ost_nxt; found_r <= found_nxt; fcur_r <= fcur_nxt;
    pkey_r <= pkey_nxt; pval_r <= pval_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_status      = ost_r;
  assign out_found_value = fval_r;
  assign out_bucket      = BucketOutW'({{BucketOutW{1'b0}}, bkt_r});

`ifndef SYNTHESIS
  a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= PW'(NODES)) else $error("free count beyond pool");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == S_IDLE) else $error("accept while busy");
  a_out_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIX |=> out_valid) else $error("no result after fix");
`endif
endmodule
